### hw/rtl/hcrs_pkg.sv
// Package for the height color ramp shader: item types, stage-to-stage structs,
// fixed-point constants and the constant breakpoint, color and reciprocal tables.
// Depends on nothing; every other file of the block uses it by scoped names.
package hcrs_pkg;

   // Default number of fraction bits of the height field.
   localparam int HEIGHT_FRAC_BITS_DEF = 8;

   localparam int NUM_TABLES = 5;
   localparam int MAX_BP     = 8;
   localparam int TAB_W      = 3;
   localparam int SEG_W      = 3;
   localparam int HALF_W     = 10;
   localparam int RECIP_W    = 25;
   localparam int COLOR_W    = 24;
   localparam int SCALE_W    = 25;
   localparam int MIX_W      = 23;
   localparam int T16_W      = 17;

   localparam logic [TAB_W-1:0] LAST_TABLE = TAB_W'(NUM_TABLES - 1);

   // Fixed-point constants.
   localparam logic [T16_W-1:0]   T_ONE       = 17'd65536;
   localparam logic [SCALE_W-1:0] Q24_ONE     = 25'd16777216;
   localparam logic [14:0]        SLOPE_LOW   = 15'd13107;
   localparam logic [14:0]        SLOPE_HIGH  = 15'd19661;
   localparam logic [8:0]         HALF_BRIGHT = 9'd128;
   localparam logic [8:0]         WHITEN_KNEE = 9'd212;
   localparam logic [15:0]        NOISE_KEEP  = 16'd64553;
   localparam logic [9:0]         NOISE_MIX   = 10'd983;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_COLOR_SCHEME = 1'b0;

   typedef struct packed {
      logic signed [18:0] height;
      logic [8:0]         brightness;
      logic [7:0]         noise_red;
      logic [7:0]         noise_green;
      logic [7:0]         noise_blue;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   // Valid bit plus the table and segment that travel with an item.
   typedef struct packed {
      logic             valid;
      logic [TAB_W-1:0] tab;
      logic [SEG_W-1:0] seg;
   } track_type;

   // Shading controls worked out once per item at the front of the pipeline.
   typedef struct packed {
      logic [SCALE_W-1:0] scale;
      logic [MIX_W-1:0]   mix;
      logic               hpos;
      logic [7:0]         noise_red;
      logic [7:0]         noise_green;
      logic [7:0]         noise_blue;
   } side_type;

   // Working color, 0..255 scale in Q16.
   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } color_type;

   // Breakpoints in half units, ascending within each table.
   localparam logic signed [HALF_W-1:0] BP_HALF [NUM_TABLES][MAX_BP] = '{
      '{-10'sd5, -10'sd1, 10'sd0, 10'sd13, 10'sd14, 10'sd20, 10'sd100, 10'sd300},
      '{-10'sd5, -10'sd1, 10'sd0, 10'sd13, 10'sd14, 10'sd20, 10'sd100, 10'sd300},
      '{-10'sd5, 10'sd1, 10'sd2, 10'sd100, 10'sd300, 10'sd0, 10'sd0, 10'sd0},
      '{-10'sd5, 10'sd1, 10'sd2, 10'sd100, 10'sd300, 10'sd0, 10'sd0, 10'sd0},
      '{-10'sd5, 10'sd1, 10'sd2, 10'sd100, 10'sd300, 10'sd0, 10'sd0, 10'sd0}
   };

   localparam logic [3:0] BP_COUNT [NUM_TABLES] = '{4'd8, 4'd8, 4'd5, 4'd5, 4'd5};

   // round(2^24 / w) per segment, w being the segment width in half units.
   localparam logic [RECIP_W-1:0] SEG_RECIP [NUM_TABLES][MAX_BP] = '{
      '{25'd4194304, 25'd16777216, 25'd1290555, 25'd16777216,
        25'd2796203, 25'd209715, 25'd83886, 25'd0},
      '{25'd4194304, 25'd16777216, 25'd1290555, 25'd16777216,
        25'd2796203, 25'd209715, 25'd83886, 25'd0},
      '{25'd2796203, 25'd16777216, 25'd171196, 25'd83886,
        25'd0, 25'd0, 25'd0, 25'd0},
      '{25'd2796203, 25'd16777216, 25'd171196, 25'd83886,
        25'd0, 25'd0, 25'd0, 25'd0},
      '{25'd2796203, 25'd16777216, 25'd171196, 25'd83886,
        25'd0, 25'd0, 25'd0, 25'd0}
   };

   // Breakpoint colors packed as {red, green, blue}.
   localparam logic [23:0] BP_RGB [NUM_TABLES][MAX_BP] = '{
      '{{8'd164, 8'd146, 8'd124}, {8'd219, 8'd186, 8'd153}, {8'd194, 8'd142, 8'd102},
        {8'd199, 8'd172, 8'd148}, {8'd177, 8'd172, 8'd132}, {8'd125, 8'd171, 8'd142},
        {8'd59, 8'd137, 8'd11}, {8'd59, 8'd137, 8'd11}},
      '{{8'd164, 8'd146, 8'd124}, {8'd219, 8'd186, 8'd153}, {8'd191, 8'd171, 8'd129},
        {8'd114, 8'd150, 8'd65}, {8'd120, 8'd150, 8'd64}, {8'd135, 8'd149, 8'd60},
        {8'd132, 8'd137, 8'd11}, {8'd132, 8'd137, 8'd11}},
      '{{8'd156, 8'd137, 8'd116}, {8'd156, 8'd137, 8'd116}, {8'd128, 8'd137, 8'd74},
        {8'd72, 8'd67, 8'd38}, {8'd72, 8'd67, 8'd38}, {8'd0, 8'd0, 8'd0},
        {8'd0, 8'd0, 8'd0}, {8'd0, 8'd0, 8'd0}},
      '{{8'd204, 8'd168, 8'd146}, {8'd204, 8'd168, 8'd146}, {8'd221, 8'd138, 8'd88},
        {8'd197, 8'd111, 8'd60}, {8'd197, 8'd111, 8'd60}, {8'd0, 8'd0, 8'd0},
        {8'd0, 8'd0, 8'd0}, {8'd0, 8'd0, 8'd0}},
      '{{8'd138, 8'd153, 8'd105}, {8'd144, 8'd149, 8'd110}, {8'd128, 8'd137, 8'd74},
        {8'd72, 8'd67, 8'd38}, {8'd72, 8'd67, 8'd38}, {8'd0, 8'd0, 8'd0},
        {8'd0, 8'd0, 8'd0}, {8'd0, 8'd0, 8'd0}}
   };

   // Width of the signed height compare path: holds the input and the largest
   // breakpoint at the given number of fraction bits.
   function automatic int cmp_width(input int frac_bits);
      return (frac_bits + 10 > 20) ? frac_bits + 10 : 20;
   endfunction

   // Width of the offset-times-reciprocal product.
   function automatic int prod_width(input int frac_bits);
      return cmp_width(frac_bits) + RECIP_W;
   endfunction

endpackage

### hw/rtl/hcrs_csr.sv
// Configuration register file of the height color ramp shader (color scheme).
// Depends on hcrs_pkg for the address and data widths and the register index.
module hcrs_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [hcrs_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [hcrs_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [hcrs_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output logic [hcrs_pkg::TAB_W-1:0]        scheme_o
);

   logic [hcrs_pkg::TAB_W-1:0] scheme_ff;
   logic [hcrs_pkg::TAB_W-1:0] scheme_in;
   logic                       hit;

   assign hit    = (paddr[hcrs_pkg::CSR_ADDR_W-1:2] == hcrs_pkg::REG_COLOR_SCHEME);
   assign pready = 1'b1;

   always_comb begin
      scheme_in = scheme_ff;
      if (psel && penable && pwrite && pready && hit) begin
         scheme_in = pwdata[hcrs_pkg::TAB_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scheme_ff <= '0;
      end else begin
         scheme_ff <= scheme_in;
      end
   end

   assign prdata   = hit ? {{(hcrs_pkg::CSR_DATA_W - hcrs_pkg::TAB_W){1'b0}}, scheme_ff} : '0;
   assign scheme_o = scheme_ff;

endmodule

### hw/rtl/hcrs_locate.sv
// Front of the shader pipeline: segment search with height clamp, brightness
// factors, then the offset-times-reciprocal product. Depends on hcrs_pkg.
module hcrs_locate #(
   parameter int HEIGHT_FRAC_BITS = hcrs_pkg::HEIGHT_FRAC_BITS_DEF
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               valid_i,
   input  hcrs_pkg::req_type                                  req_i,
   input  logic [hcrs_pkg::TAB_W-1:0]                         scheme_i,
   output hcrs_pkg::track_type                                track_o,
   output hcrs_pkg::side_type                                 side_o,
   output logic [hcrs_pkg::prod_width(HEIGHT_FRAC_BITS)-1:0]  prod_o
);

   localparam int CMP_W = hcrs_pkg::cmp_width(HEIGHT_FRAC_BITS);
   localparam int PW    = hcrs_pkg::prod_width(HEIGHT_FRAC_BITS);

   // Breakpoint k of table t in height units.
   function automatic logic signed [CMP_W-1:0] bp_at(
      input logic [hcrs_pkg::TAB_W-1:0] t,
      input logic [hcrs_pkg::SEG_W-1:0] k
   );
      logic signed [hcrs_pkg::HALF_W-1:0] half;
      half = hcrs_pkg::BP_HALF[t][k];
      return {{(CMP_W - hcrs_pkg::HALF_W){half[hcrs_pkg::HALF_W-1]}}, half}
             << (HEIGHT_FRAC_BITS - 1);
   endfunction

   // Stage 1 logic.
   logic [hcrs_pkg::TAB_W-1:0] tab;
   logic [3:0]                 n;
   logic signed [CMP_W-1:0]    h_ext;
   logic signed [CMP_W-1:0]    lo;
   logic signed [CMP_W-1:0]    hi;
   logic signed [CMP_W-1:0]    hc;
   logic [hcrs_pkg::SEG_W-1:0] seg;
   logic [8:0]                 bdiff;
   logic [22:0]                slope_prod;
   hcrs_pkg::side_type         side;

   // Stage registers.
   logic                       s1_valid_ff, s1_valid_in;
   logic [hcrs_pkg::TAB_W-1:0] s1_tab_ff;
   logic [hcrs_pkg::SEG_W-1:0] s1_seg_ff;
   logic [CMP_W-1:0]           s1_d_ff;
   hcrs_pkg::side_type         s1_side_ff;
   logic                       s2_valid_ff;
   logic [hcrs_pkg::TAB_W-1:0] s2_tab_ff;
   logic [hcrs_pkg::SEG_W-1:0] s2_seg_ff;
   hcrs_pkg::side_type         s2_side_ff;
   logic [PW-1:0]              s2_prod_ff, s2_prod_in;
   logic [hcrs_pkg::RECIP_W-1:0] recip;

   always_comb begin
      // Unused scheme codes fall back to the default palette.
      tab   = (scheme_i <= hcrs_pkg::LAST_TABLE) ? scheme_i : '0;
      n     = hcrs_pkg::BP_COUNT[tab];
      h_ext = {{(CMP_W - 19){req_i.height[18]}}, req_i.height};
      seg   = '0;
      // Breakpoints ascend, so the last inner breakpoint below the height
      // marks the segment.
      for (int k = 1; k <= hcrs_pkg::MAX_BP - 2; k++) begin
         if ((4'(k + 2) <= n) && (h_ext > bp_at(tab, hcrs_pkg::SEG_W'(k)))) begin
            seg = hcrs_pkg::SEG_W'(k);
         end
      end
      lo = bp_at(tab, seg);
      hi = bp_at(tab, seg + hcrs_pkg::SEG_W'(1));
      if (h_ext < lo) begin
         hc = lo;
      end else if (h_ext > hi) begin
         hc = hi;
      end else begin
         hc = h_ext;
      end

      // Brightness: darken below one half, else whiten with the low or the
      // high slope.
      if (req_i.brightness < hcrs_pkg::HALF_BRIGHT) begin
         bdiff      = hcrs_pkg::HALF_BRIGHT - req_i.brightness;
         slope_prod = 23'(hcrs_pkg::SLOPE_LOW) * 23'(bdiff);
         side.mix   = '0;
      end else begin
         bdiff = req_i.brightness - hcrs_pkg::HALF_BRIGHT;
         if (req_i.brightness > hcrs_pkg::WHITEN_KNEE) begin
            slope_prod = 23'(hcrs_pkg::SLOPE_HIGH) * 23'(bdiff);
         end else begin
            slope_prod = 23'(hcrs_pkg::SLOPE_LOW) * 23'(bdiff);
         end
         side.mix = slope_prod;
      end
      side.scale       = hcrs_pkg::Q24_ONE - 25'(slope_prod);
      side.hpos        = !req_i.height[18] && (|req_i.height[17:0]);
      side.noise_red   = req_i.noise_red;
      side.noise_green = req_i.noise_green;
      side.noise_blue  = req_i.noise_blue;
   end

   assign s1_valid_in = valid_i;
   assign recip       = hcrs_pkg::SEG_RECIP[s1_tab_ff][s1_seg_ff];
   assign s2_prod_in  = PW'(s1_d_ff) * PW'(recip);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_tab_ff  <= tab;
      s1_seg_ff  <= seg;
      s1_d_ff    <= CMP_W'(hc - lo);
      s1_side_ff <= side;
      s2_tab_ff  <= s1_tab_ff;
      s2_seg_ff  <= s1_seg_ff;
      s2_side_ff <= s1_side_ff;
      s2_prod_ff <= s2_prod_in;
   end

   assign track_o.valid = s2_valid_ff;
   assign track_o.tab   = s2_tab_ff;
   assign track_o.seg   = s2_seg_ff;
   assign side_o        = s2_side_ff;
   assign prod_o        = s2_prod_ff;

endmodule

### hw/rtl/hcrs_interp.sv
// Interpolation stages: rounds the product into the Q16 position t16 within the
// segment, then blends the two breakpoint colors. Depends on hcrs_pkg.
module hcrs_interp #(
   parameter int HEIGHT_FRAC_BITS = hcrs_pkg::HEIGHT_FRAC_BITS_DEF
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  hcrs_pkg::track_type                                track_i,
   input  hcrs_pkg::side_type                                 side_i,
   input  logic [hcrs_pkg::prod_width(HEIGHT_FRAC_BITS)-1:0]  prod_i,
   output logic                                               valid_o,
   output hcrs_pkg::color_type                                color_o,
   output hcrs_pkg::side_type                                 side_o
);

   localparam int PW = hcrs_pkg::prod_width(HEIGHT_FRAC_BITS);

   function automatic logic [hcrs_pkg::COLOR_W-1:0] blend(
      input logic [7:0]                 c1,
      input logic [7:0]                 c2,
      input logic [hcrs_pkg::T16_W-1:0] t16
   );
      logic [hcrs_pkg::T16_W-1:0] rest;
      logic [24:0]                acc;
      rest = hcrs_pkg::T_ONE - t16;
      acc  = 25'(c1) * 25'(rest) + 25'(c2) * 25'(t16);
      return acc[hcrs_pkg::COLOR_W-1:0];
   endfunction

   logic [PW:0]                 round_sum;
   logic [PW:0]                 tq;
   logic [hcrs_pkg::T16_W-1:0]  t16_in;
   logic                        s3_valid_ff;
   logic [hcrs_pkg::TAB_W-1:0]  s3_tab_ff;
   logic [hcrs_pkg::SEG_W-1:0]  s3_seg_ff;
   logic [hcrs_pkg::T16_W-1:0]  s3_t16_ff;
   hcrs_pkg::side_type          s3_side_ff;
   logic [23:0]                 c1;
   logic [23:0]                 c2;
   logic                        s4_valid_ff;
   hcrs_pkg::color_type         s4_color_ff, s4_color_in;
   hcrs_pkg::side_type          s4_side_ff;

   always_comb begin
      round_sum = {1'b0, prod_i} + ((PW + 1)'(1) << (HEIGHT_FRAC_BITS + 6));
      tq        = round_sum >> (HEIGHT_FRAC_BITS + 7);
      t16_in    = (tq > (PW + 1)'(hcrs_pkg::T_ONE)) ? hcrs_pkg::T_ONE
                                                    : tq[hcrs_pkg::T16_W-1:0];
   end

   always_comb begin
      c1 = hcrs_pkg::BP_RGB[s3_tab_ff][s3_seg_ff];
      c2 = hcrs_pkg::BP_RGB[s3_tab_ff][s3_seg_ff + hcrs_pkg::SEG_W'(1)];
      s4_color_in.red   = blend(c1[23:16], c2[23:16], s3_t16_ff);
      s4_color_in.green = blend(c1[15:8], c2[15:8], s3_t16_ff);
      s4_color_in.blue  = blend(c1[7:0], c2[7:0], s3_t16_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= track_i.valid;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_tab_ff   <= track_i.tab;
      s3_seg_ff   <= track_i.seg;
      s3_t16_ff   <= t16_in;
      s3_side_ff  <= side_i;
      s4_color_ff <= s4_color_in;
      s4_side_ff  <= s3_side_ff;
   end

   assign valid_o = s4_valid_ff;
   assign color_o = s4_color_ff;
   assign side_o  = s4_side_ff;

endmodule

### hw/rtl/hcrs_shade.sv
// Shading stages: brightness darken or whiten, noise mix above zero height, and
// the rounded, saturated 8-bit output register. Depends on hcrs_pkg.
module hcrs_shade (
   input  logic                clock,
   input  logic                reset,
   input  logic                valid_i,
   input  hcrs_pkg::color_type color_i,
   input  hcrs_pkg::side_type  side_i,
   output logic                valid_o,
   output hcrs_pkg::rsp_type   rsp_o
);

   // C * scale + 255 * mix in Q24, rounded back to Q16.
   function automatic logic [hcrs_pkg::COLOR_W-1:0] light(
      input logic [hcrs_pkg::COLOR_W-1:0] c,
      input logic [hcrs_pkg::SCALE_W-1:0] scale,
      input logic [hcrs_pkg::MIX_W-1:0]   mix
   );
      logic [49:0] acc;
      acc = 50'(c) * 50'(scale) + ((50'(mix) * 50'd255) << 16) + 50'd8388608;
      return acc[47:24];
   endfunction

   function automatic logic [hcrs_pkg::COLOR_W-1:0] noisy(
      input logic [hcrs_pkg::COLOR_W-1:0] c,
      input logic [7:0]                   noise
   );
      logic [40:0] acc;
      acc = 41'(c) * 41'(hcrs_pkg::NOISE_KEEP)
          + ((41'(noise) * 41'(hcrs_pkg::NOISE_MIX)) << 16) + 41'd32768;
      return acc[39:16];
   endfunction

   function automatic logic [7:0] to_byte(input logic [hcrs_pkg::COLOR_W-1:0] c);
      logic [24:0] acc;
      acc = 25'(c) + 25'd32768;
      return (acc[24:16] > 9'd255) ? 8'd255 : acc[23:16];
   endfunction

   logic                s5_valid_ff;
   hcrs_pkg::color_type s5_color_ff, s5_color_in;
   hcrs_pkg::side_type  s5_side_ff;
   logic                s6_valid_ff;
   hcrs_pkg::color_type s6_color_ff, s6_color_in;
   logic                out_valid_ff;
   hcrs_pkg::rsp_type   out_rsp_ff, out_rsp_in;

   always_comb begin
      s5_color_in.red   = light(color_i.red, side_i.scale, side_i.mix);
      s5_color_in.green = light(color_i.green, side_i.scale, side_i.mix);
      s5_color_in.blue  = light(color_i.blue, side_i.scale, side_i.mix);
   end

   always_comb begin
      if (s5_side_ff.hpos) begin
         s6_color_in.red   = noisy(s5_color_ff.red, s5_side_ff.noise_red);
         s6_color_in.green = noisy(s5_color_ff.green, s5_side_ff.noise_green);
         s6_color_in.blue  = noisy(s5_color_ff.blue, s5_side_ff.noise_blue);
      end else begin
         s6_color_in = s5_color_ff;
      end
   end

   always_comb begin
      out_rsp_in.red   = to_byte(s6_color_ff.red);
      out_rsp_in.green = to_byte(s6_color_ff.green);
      out_rsp_in.blue  = to_byte(s6_color_ff.blue);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff  <= valid_i;
         s6_valid_ff  <= s5_valid_ff;
         out_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s5_color_ff <= s5_color_in;
      s5_side_ff  <= side_i;
      s6_color_ff <= s6_color_in;
      out_rsp_ff  <= out_rsp_in;
   end

   assign valid_o = out_valid_ff;
   assign rsp_o   = out_rsp_ff;

endmodule

### hw/rtl/height_color_ramp_shader_top.sv
// Height color ramp shader, top level. Instantiates hcrs_csr, hcrs_locate,
// hcrs_interp and hcrs_shade; depends on hcrs_pkg for types and tables.
//
// Usage: an item (height, brightness, noise color) is taken at each rising
// clock edge where start is high and busy is low. busy never rises, so one
// item may be presented in every cycle, back to back, indefinitely.
// Each item yields exactly one result, shown on rsp_data for a single cycle
// while rsp_valid is high. Results leave in the order the items came in.
// The pipeline has seven register stages: segment search with clamp, the
// offset-times-reciprocal multiply, t16 rounding, color blend, brightness
// shading, noise mix and the output register. Throughput is one item per
// clock; the deepest stage is the brightness shading with its 24-bit by 25-bit multiply.
// The receiver has no way to hold results back, so nothing in the pipeline
// ever stalls; a result that is not captured in its cycle is gone.
// The color scheme register is written through the APB-style port, and
// should only change while no item is in flight. Synchronous reset clears
// the register to the default palette and drops every item in flight; no
// result appears until a new item is started.
module height_color_ramp_shader_top #(
   parameter int HEIGHT_FRAC_BITS = hcrs_pkg::HEIGHT_FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  hcrs_pkg::req_type                req_data,
   output logic                             rsp_valid,
   output hcrs_pkg::rsp_type                rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [hcrs_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [hcrs_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [hcrs_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);

   localparam int PW = hcrs_pkg::prod_width(HEIGHT_FRAC_BITS);

   logic [hcrs_pkg::TAB_W-1:0] scheme;
   logic                       accept;
   hcrs_pkg::track_type        loc_track;
   hcrs_pkg::side_type         loc_side;
   logic [PW-1:0]              loc_prod;
   logic                       int_valid;
   hcrs_pkg::color_type        int_color;
   hcrs_pkg::side_type         int_side;

   // Every stage advances each cycle, so the block can always take an item.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   hcrs_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .scheme_o (scheme)
   );

   hcrs_locate #(
      .HEIGHT_FRAC_BITS (HEIGHT_FRAC_BITS)
   ) u_locate (
      .clock    (clock),
      .reset    (reset),
      .valid_i  (accept),
      .req_i    (req_data),
      .scheme_i (scheme),
      .track_o  (loc_track),
      .side_o   (loc_side),
      .prod_o   (loc_prod)
   );

   hcrs_interp #(
      .HEIGHT_FRAC_BITS (HEIGHT_FRAC_BITS)
   ) u_interp (
      .clock   (clock),
      .reset   (reset),
      .track_i (loc_track),
      .side_i  (loc_side),
      .prod_i  (loc_prod),
      .valid_o (int_valid),
      .color_o (int_color),
      .side_o  (int_side)
   );

   hcrs_shade u_shade (
      .clock   (clock),
      .reset   (reset),
      .valid_i (int_valid),
      .color_i (int_color),
      .side_i  (int_side),
      .valid_o (rsp_valid),
      .rsp_o   (rsp_data)
   );

endmodule
